// File: rtl/core/bpc_pkg.sv
// Shared types and constants for the button press classifier.
`default_nettype none

package bpc_pkg;

    localparam int BUTTONS_DEF = 8;
    localparam int SAMPLES_DEF = 4;

    localparam int IDX_W  = 3;
    localparam int PIN_W  = 4;
    localparam int TMR_W  = 16;
    localparam int CNT_W  = 8;
    localparam int CFG_W  = 8;
    localparam int CFGA_W = 1;

    localparam logic [CFG_W-1:0] UP_THR_RST   = 8'd2;
    localparam logic [CFG_W-1:0] DOWN_THR_RST = 8'd5;

    // configuration register indexes
    localparam logic [CFGA_W-1:0] CFG_UP_THR   = 1'd0;
    localparam logic [CFGA_W-1:0] CFG_DOWN_THR = 1'd1;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_POLL = 1'b1;

    typedef enum logic [1:0] {
        CLS_UP    = 2'd0,
        CLS_CLICK = 2'd1,
        CLS_DOWN  = 2'd2,
        CLS_LONG  = 2'd3
    } t_class;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POLL,
        ST_TICK
    } t_state;

    // one button's state word as kept in the RAM
    typedef struct packed {
        logic             tmr_en;
        logic [CNT_W-1:0] press_cnt;
        logic [TMR_W-1:0] hold_tmr;
        t_class           cls;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

`default_nettype wire

// File: rtl/core/bpc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none

module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/button_press_classifier.sv
// Top level of the button press classifier: debounce, click and long-press detection.
`default_nettype none

// Debounce and click / long-press classifier for up to BUTTONS active-low buttons.
// Each input beat is either a millisecond tick (mode 0) or a poll of one button
// (mode 1). A poll is pressed when all examined pin samples are low; the result
// beat carries the button's new class (up, click, held down, long press). A tick
// gives no result. Per-button state lives in one RAM with a registered read; a
// per-entry valid bit makes unwritten entries read as the reset state. A poll is
// accepted, then read-modify-written, waiting on any stall of the result register;
// a tick walks every entry through the RAM's single read and write port, one
// entry per cycle, so the next beat is taken once the walk is done. A poll whose
// index is not below BUTTONS is taken and dropped. The user must write thresholds
// through the configuration port while the block is idle; it does not enforce this.
module button_press_classifier #(
    parameter int BUTTONS = bpc_pkg::BUTTONS_DEF,
    parameter int SAMPLES = bpc_pkg::SAMPLES_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [bpc_pkg::CFGA_W-1:0] i_cfg_idx,
    input  wire logic [bpc_pkg::CFG_W-1:0]  i_cfg_data,
    input  wire logic                       i_in_valid,
    output logic                            o_in_ready,
    input  wire logic                       i_mode,
    input  wire logic [bpc_pkg::IDX_W-1:0]  i_button_index,
    input  wire logic [bpc_pkg::PIN_W-1:0]  i_pin_samples,
    input  wire logic [bpc_pkg::TMR_W-1:0]  i_long_press_ticks,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output logic [1:0]                      o_button_class
);

    import bpc_pkg::*;

    localparam int AW = (BUTTONS > 1) ? $clog2(BUTTONS) : 1;
    localparam int CW = $clog2(BUTTONS + 1);
    localparam logic [PIN_W-1:0] PinMask =
        (SAMPLES >= PIN_W) ? {PIN_W{1'b1}} : PIN_W'((1 << SAMPLES) - 1);

    t_state r_state, n_state;

    logic [CFG_W-1:0]   r_up_thr, r_down_thr;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]      r_addr, n_addr;
    logic [BUTTONS-1:0] r_vld, n_vld;
    logic [PIN_W-1:0]   r_pins;
    logic [TMR_W-1:0]   r_reload;
    logic               r_out_valid, n_out_valid;
    logic [1:0]         r_out_class, n_out_class;

    logic               in_acc, poll_in_range, out_free, walk_done;
    logic               ram_we, ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             cur, poll_upd, tick_upd, wr_entry;
    logic               pressed;
    logic [CNT_W-1:0]   cnt_nx;

    assign in_acc        = i_in_valid && o_in_ready;
    assign poll_in_range = {{(32 - IDX_W){1'b0}}, i_button_index} < 32'(BUTTONS);
    assign out_free      = !r_out_valid || i_out_ready;
    assign walk_done     = (r_cnt == CW'(BUTTONS));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_mode == MODE_TICK) begin
                        n_state = ST_TICK;
                    end else if (poll_in_range) begin
                        n_state = ST_POLL;
                    end
                end
            end
            ST_POLL: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (walk_done) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // entry update
    always_comb begin
        cur      = r_vld[r_addr] ? t_entry'(ram_rdata) : '0;
        pressed  = (r_pins & PinMask) == '0;
        poll_upd = cur;
        if (pressed) begin
            poll_upd.tmr_en = 1'b1;
            if (cur.press_cnt < r_down_thr) begin
                poll_upd.press_cnt = cur.press_cnt + CNT_W'(1);
            end
        end else begin
            poll_upd.tmr_en    = 1'b0;
            poll_upd.press_cnt = '0;
            poll_upd.hold_tmr  = r_reload;
        end
        cnt_nx = poll_upd.press_cnt;
        if (cnt_nx <= r_up_thr) begin
            poll_upd.cls = CLS_UP;
        end else if (cnt_nx <= r_down_thr) begin
            case (cur.cls)
                CLS_UP:    poll_upd.cls = CLS_CLICK;
                CLS_CLICK: poll_upd.cls = CLS_DOWN;
                CLS_DOWN:  poll_upd.cls = (poll_upd.hold_tmr == '0) ? CLS_LONG : CLS_DOWN;
                default:   poll_upd.cls = cur.cls;
            endcase
        end

        tick_upd = cur;
        // timer stops at zero
        if (cur.tmr_en && cur.hold_tmr != '0) begin
            tick_upd.hold_tmr = cur.hold_tmr - TMR_W'(1);
        end
    end

    // outputs and datapath control
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        ram_re      = 1'b0;
        ram_raddr   = r_cnt[AW-1:0];
        ram_we      = 1'b0;
        wr_entry    = tick_upd;
        n_cnt       = r_cnt;
        n_addr      = r_addr;
        n_vld       = r_vld;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_class = r_out_class;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (in_acc && i_mode == MODE_POLL && poll_in_range) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(i_button_index);
                    n_addr    = AW'(i_button_index);
                end
            end
            ST_POLL: begin
                wr_entry = poll_upd;
                if (out_free) begin
                    ram_we        = 1'b1;
                    n_vld[r_addr] = 1'b1;
                    n_out_valid   = 1'b1;
                    n_out_class   = poll_upd.cls;
                end
            end
            ST_TICK: begin
                // read entry r_cnt while writing back the one read last cycle
                if (!walk_done) begin
                    ram_re = 1'b1;
                    n_cnt  = r_cnt + CW'(1);
                    n_addr = r_cnt[AW-1:0];
                end
                if (r_cnt != '0) begin
                    ram_we        = 1'b1;
                    n_vld[r_addr] = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_up_thr    <= UP_THR_RST;
            r_down_thr  <= DOWN_THR_RST;
            r_cnt       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_vld       <= n_vld;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_UP_THR:   r_up_thr   <= i_cfg_data;
                    CFG_DOWN_THR: r_down_thr <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_out_class <= n_out_class;
        if (in_acc) begin
            r_pins   <= i_pin_samples;
            r_reload <= i_long_press_ticks;
        end
    end

    bpc_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (BUTTONS),
        .AW    (AW)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_addr),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_out_valid    = r_out_valid;
    assign o_button_class = r_out_class;

endmodule

`default_nettype wire

// File: rtl/core/bpc_checker.sv
// Port-level checks for the button press classifier, bound to the top level.
`default_nettype none

module bpc_checker #(
    parameter int BUTTONS = bpc_pkg::BUTTONS_DEF
) (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_in_valid,
    input wire logic                       o_in_ready,
    input wire logic                       i_mode,
    input wire logic [bpc_pkg::IDX_W-1:0]  i_button_index,
    input wire logic                       o_out_valid,
    input wire logic                       i_out_ready,
    input wire logic [1:0]                 o_button_class
);

    import bpc_pkg::*;

    logic in_acc, idx_ok;

    assign in_acc = i_in_valid && o_in_ready;
    assign idx_ok = {{(32 - IDX_W){1'b0}}, i_button_index} < 32'(BUTTONS);

    // a tick walks the RAM, so the next beat cannot follow at once
    a_tick_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_mode == MODE_TICK |=> !o_in_ready)
        else $error("input taken right after a tick");

    a_poll_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_mode == MODE_POLL && idx_ok |=> !o_in_ready)
        else $error("input taken right after a poll");

    // out-of-range polls are dropped without going busy
    a_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_mode == MODE_POLL && !idx_ok |=> o_in_ready && !$rose(o_out_valid))
        else $error("out-of-range poll produced work");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_button_class))
        else $error("stalled result beat changed");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_out_valid) |-> $past(i_out_ready))
        else $error("result beat withdrawn without handshake");

endmodule

bind button_press_classifier bpc_checker #(
    .BUTTONS (BUTTONS)
) u_bpc_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_in_valid         (i_in_valid),
    .o_in_ready         (o_in_ready),
    .i_mode             (i_mode),
    .i_button_index     (i_button_index),
    .o_out_valid        (o_out_valid),
    .i_out_ready        (i_out_ready),
    .o_button_class     (o_button_class)
);

`default_nettype wire
